### hw/rtl/gld_pkg.sv
// ----------------------------------------------------------------------------
// gld_pkg
// Shared constants for the GIF LZW decoder: sizes, commands and stop codes.
// ----------------------------------------------------------------------------
package gld_pkg;

	localparam int unsigned MAX_PIXELS = 65536;
	localparam int unsigned DICT_SIZE  = 4096;
	localparam int unsigned MAX_WIDTH  = 12;

	localparam int unsigned PIX_AW  = $clog2(MAX_PIXELS);
	localparam int unsigned CNT_W   = PIX_AW + 1;
	localparam int unsigned DICT_AW = $clog2(DICT_SIZE);

	localparam logic [3:0] MCS_RESET = 4'd8;
	localparam logic [3:0] MCS_MIN   = 4'd2;
	localparam logic [3:0] MCS_MAX   = 4'd8;

	typedef enum logic [1:0] {
		CMD_START = 2'd0,
		CMD_DATA  = 2'd1,
		CMD_READ  = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		STOP_RUNNING = 3'd0,
		STOP_END     = 3'd1,
		STOP_FULL    = 3'd2,
		STOP_INVALID = 3'd3,
		STOP_DATA    = 3'd4
	} stop_t;

	localparam logic REG_MIN_CODE_SIZE = 1'b0;
	localparam logic REG_PIXEL_LIMIT   = 1'b1;

endpackage

### hw/rtl/gif_lzw_decoder.sv
// ----------------------------------------------------------------------------
// gif_lzw_decoder
// GIF variable-width LZW decoder with dictionary, string stack and pixel store.
//
// channel  | handshake            | payload
// ---------+----------------------+-------------------------------------------
// in       | in_valid / in_ready  | command, data_byte, last_byte, read_address
// out      | out_valid / out_ready| pixel_value, decoded_count, stop_reason
// cfg      | cfg_write            | cfg_index, cfg_data
//
// Start, read and no-op commands go from idle straight to the done state. A
// data byte enters the extract state, which handles a clear, end, literal or
// invalid code in place; other codes walk the dictionary (walk check, wait),
// pop pixels (pop read, write), finish; registered memory reads set the steps.
// Reset is asynchronous and clears control state only. A result that is not
// taken holds the block in its final state; one new transfer is taken meanwhile.
// ----------------------------------------------------------------------------
module gif_lzw_decoder (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_write,
	input  logic                      cfg_index,
	input  logic [16:0]               cfg_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [1:0]                command,
	input  logic [7:0]                data_byte,
	input  logic                      last_byte,
	input  logic [15:0]               read_address,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [7:0]                pixel_value,
	output logic [16:0]               decoded_count,
	output logic [2:0]                stop_reason
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EXTRACT,
		ST_WALK_CHK,
		ST_WALK_WAIT,
		ST_POP_RD,
		ST_POP_WR,
		ST_FINISH,
		ST_DONE
	} state_t;

	localparam int unsigned DW = gld_pkg::DICT_AW;
	localparam int unsigned PW = gld_pkg::PIX_AW;
	localparam int unsigned CW = gld_pkg::CNT_W;

	state_t          state_q;
	logic [3:0]      mcs_cfg_q;
	logic [16:0]     limit_cfg_q;
	logic [3:0]      mcs_q;
	logic [19:0]     buf_q;
	logic [4:0]      cnt_q;
	logic [3:0]      cw_q;
	logic [DW:0]     next_q;
	logic [DW-1:0]   prev_q;
	logic            await_q;
	logic [CW-1:0]   out_q;
	gld_pkg::stop_t  halt_q;
	logic            last_q;
	logic            rd_cmd_q;
	logic [DW-1:0]   code_q;
	logic            kwk_q;
	logic [DW-1:0]   walk_q;
	logic [DW:0]     depth_q;
	logic [7:0]      root_q;

	logic [DW+7:0]   dict_mem [gld_pkg::DICT_SIZE];
	logic [7:0]      chain_mem [gld_pkg::DICT_SIZE];
	logic [7:0]      pix_mem [gld_pkg::MAX_PIXELS];
	logic [DW+7:0]   dict_rd_q;
	logic [7:0]      chain_rd_q;
	logic [7:0]      pix_rd_q;

	logic            dict_we, dict_re, chain_we, chain_re, pix_we, pix_re;
	logic [DW-1:0]   dict_waddr, dict_raddr, chain_waddr, chain_raddr;
	logic [DW+7:0]   dict_wdata;
	logic [7:0]      chain_wdata, pix_wdata;
	logic [PW-1:0]   pix_waddr, pix_raddr;

	logic [CW-1:0]   lim;
	logic [DW-1:0]   clr;
	logic [DW-1:0]   mask;
	logic [DW-1:0]   code;
	logic            have_code;
	logic            accept;
	logic            start_bad;
	logic [DW:0]     depth_m1;
	logic            pop_go;
	logic            fin_put;
	logic            fin_add;
	logic [CW-1:0]   out_inc;

	assign lim = (limit_cfg_q > CW'(gld_pkg::MAX_PIXELS)) ?
		CW'(gld_pkg::MAX_PIXELS) : CW'(limit_cfg_q);
	assign clr       = DW'(1) << mcs_q;
	assign mask      = DW'((DW'(1) << cw_q) - 1'b1);
	assign code      = buf_q[DW-1:0] & mask;
	assign have_code = (halt_q == gld_pkg::STOP_RUNNING) && (cnt_q >= 5'(cw_q));
	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign start_bad = (mcs_cfg_q < gld_pkg::MCS_MIN) || (mcs_cfg_q > gld_pkg::MCS_MAX);
	assign depth_m1  = depth_q - 1'b1;
	assign pop_go    = (depth_q != '0) && (out_q < lim);
	assign fin_put   = kwk_q && (out_q < lim);
	assign fin_add   = (!kwk_q || (out_q < lim)) && (next_q < (DW+1)'(gld_pkg::DICT_SIZE));
	assign out_inc   = out_q + 1'b1;

	always_comb begin
		dict_we     = 1'b0;
		dict_waddr  = next_q[DW-1:0];
		dict_wdata  = {prev_q, root_q};
		dict_re     = (state_q == ST_WALK_CHK) && (walk_q >= clr);
		dict_raddr  = walk_q;
		chain_we    = 1'b0;
		chain_waddr = depth_q[DW-1:0];
		chain_wdata = walk_q[7:0];
		chain_re    = (state_q == ST_POP_RD) && pop_go;
		chain_raddr = depth_m1[DW-1:0];
		pix_we      = 1'b0;
		pix_waddr   = out_q[PW-1:0];
		pix_wdata   = chain_rd_q;
		pix_re      = accept && (gld_pkg::cmd_t'(command) == gld_pkg::CMD_READ);
		pix_raddr   = read_address;
		unique case (state_q)
			ST_EXTRACT: begin
				if (have_code && await_q && (code < clr)) begin
					pix_we    = 1'b1;
					pix_wdata = code[7:0];
				end
			end
			ST_WALK_CHK: begin
				chain_we = (walk_q < clr);
			end
			ST_WALK_WAIT: begin
				chain_we    = 1'b1;
				chain_wdata = dict_rd_q[7:0];
			end
			ST_POP_WR: begin
				pix_we = 1'b1;
			end
			ST_FINISH: begin
				pix_we    = fin_put;
				pix_wdata = root_q;
				dict_we   = fin_add;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (dict_we) dict_mem[dict_waddr] <= dict_wdata;
		if (dict_re) dict_rd_q <= dict_mem[dict_raddr];
	end

	always_ff @(posedge clk) begin
		if (chain_we) chain_mem[chain_waddr] <= chain_wdata;
		if (chain_re) chain_rd_q <= chain_mem[chain_raddr];
	end

	always_ff @(posedge clk) begin
		if (pix_we) pix_mem[pix_waddr] <= pix_wdata;
		if (pix_re) pix_rd_q <= pix_mem[pix_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			mcs_cfg_q     <= gld_pkg::MCS_RESET;
			limit_cfg_q   <= 17'(gld_pkg::MAX_PIXELS);
			mcs_q         <= gld_pkg::MCS_RESET;
			buf_q         <= '0;
			cnt_q         <= '0;
			cw_q          <= gld_pkg::MCS_RESET + 4'd1;
			next_q        <= (DW+1)'((1 << gld_pkg::MCS_RESET) + 2);
			prev_q        <= '0;
			await_q       <= 1'b1;
			out_q         <= '0;
			halt_q        <= gld_pkg::STOP_RUNNING;
			last_q        <= 1'b0;
			rd_cmd_q      <= 1'b0;
			code_q        <= '0;
			kwk_q         <= 1'b0;
			walk_q        <= '0;
			depth_q       <= '0;
			root_q        <= '0;
			out_valid     <= 1'b0;
			pixel_value   <= '0;
			decoded_count <= '0;
			stop_reason   <= '0;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					gld_pkg::REG_MIN_CODE_SIZE: mcs_cfg_q <= cfg_data[3:0];
					gld_pkg::REG_PIXEL_LIMIT:   limit_cfg_q <= cfg_data;
					default: ;
				endcase
			end
			if (out_ready && (state_q != ST_DONE)) out_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						rd_cmd_q <= (gld_pkg::cmd_t'(command) == gld_pkg::CMD_READ);
						last_q   <= last_byte;
						state_q  <= ST_DONE;
						unique case (gld_pkg::cmd_t'(command))
							gld_pkg::CMD_START: begin
								mcs_q   <= start_bad ? gld_pkg::MCS_RESET : mcs_cfg_q;
								cw_q    <= (start_bad ? gld_pkg::MCS_RESET : mcs_cfg_q) + 4'd1;
								next_q  <= ((DW+1)'(1) << (start_bad ? gld_pkg::MCS_RESET :
									mcs_cfg_q)) + (DW+1)'(2);
								prev_q  <= '0;
								await_q <= 1'b1;
								buf_q   <= '0;
								cnt_q   <= '0;
								out_q   <= '0;
								if (start_bad) halt_q <= gld_pkg::STOP_INVALID;
								else if (lim == '0) halt_q <= gld_pkg::STOP_FULL;
								else halt_q <= gld_pkg::STOP_RUNNING;
							end
							gld_pkg::CMD_DATA: begin
								if (halt_q == gld_pkg::STOP_RUNNING) begin
									if (out_q >= lim) begin
										halt_q <= gld_pkg::STOP_FULL;
									end else begin
										buf_q   <= buf_q | 20'({12'b0, data_byte} << cnt_q);
										cnt_q   <= cnt_q + 5'd8;
										state_q <= ST_EXTRACT;
									end
								end
							end
							default: ;
						endcase
					end
				end
				ST_EXTRACT: begin
					if (have_code) begin
						buf_q <= buf_q >> cw_q;
						cnt_q <= cnt_q - 5'(cw_q);
						if (code == clr + 1'b1) begin
							halt_q <= gld_pkg::STOP_END;
						end else if (code == clr) begin
							cw_q    <= mcs_q + 4'd1;
							next_q  <= (DW+1)'(clr) + (DW+1)'(2);
							prev_q  <= '0;
							await_q <= 1'b1;
						end else if (await_q) begin
							if (code > clr) begin
								halt_q <= gld_pkg::STOP_INVALID;
							end else begin
								out_q   <= out_inc;
								prev_q  <= code;
								await_q <= 1'b0;
								if (out_inc >= lim) halt_q <= gld_pkg::STOP_FULL;
							end
						end else if ((DW+1)'(code) > next_q) begin
							halt_q <= gld_pkg::STOP_INVALID;
						end else begin
							code_q  <= code;
							kwk_q   <= ((DW+1)'(code) == next_q);
							walk_q  <= ((DW+1)'(code) == next_q) ? prev_q : code;
							depth_q <= '0;
							state_q <= ST_WALK_CHK;
						end
					end else begin
						if ((halt_q == gld_pkg::STOP_RUNNING) && last_q)
							halt_q <= gld_pkg::STOP_DATA;
						state_q <= ST_DONE;
					end
				end
				ST_WALK_CHK: begin
					if (walk_q < clr) begin
						root_q  <= walk_q[7:0];
						depth_q <= depth_q + 1'b1;
						state_q <= ST_POP_RD;
					end else begin
						state_q <= ST_WALK_WAIT;
					end
				end
				ST_WALK_WAIT: begin
					depth_q <= depth_q + 1'b1;
					walk_q  <= dict_rd_q[DW+7:8];
					state_q <= ST_WALK_CHK;
				end
				ST_POP_RD: begin
					if (pop_go) begin
						depth_q <= depth_m1;
						state_q <= ST_POP_WR;
					end else begin
						state_q <= ST_FINISH;
					end
				end
				ST_POP_WR: begin
					out_q   <= out_inc;
					state_q <= ST_POP_RD;
				end
				ST_FINISH: begin
					state_q <= ST_EXTRACT;
					if (kwk_q && (out_q >= lim)) begin
						halt_q <= gld_pkg::STOP_FULL;
					end else begin
						if (fin_put) begin
							out_q <= out_inc;
							if (out_inc >= lim) halt_q <= gld_pkg::STOP_FULL;
						end else if (out_q >= lim) begin
							halt_q <= gld_pkg::STOP_FULL;
						end
						if (fin_add) begin
							next_q <= next_q + 1'b1;
							if (((next_q + 1'b1) >= ((DW+1)'(1) << cw_q)) &&
								(cw_q < 4'(gld_pkg::MAX_WIDTH)))
								cw_q <= cw_q + 4'd1;
						end
						prev_q <= code_q;
					end
				end
				ST_DONE: begin
					if (!out_valid || out_ready) begin
						out_valid     <= 1'b1;
						pixel_value   <= rd_cmd_q ? pix_rd_q : 8'd0;
						decoded_count <= out_q;
						stop_reason   <= halt_q;
						state_q       <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### test/gif_lzw_decoder_check.sv
// ----------------------------------------------------------------------------
// gif_lzw_decoder_check
// Watches the input, output and register ports of the decoder, keeps its own
// model of the bit unpacker, dictionary and pixel store, and compares every
// result transfer with the oldest predicted one.
// ----------------------------------------------------------------------------
module gif_lzw_decoder_check
	import gld_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic        cfg_index,
	input  logic [16:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  command,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	input  logic [15:0] read_address,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [7:0]  pixel_value,
	input  logic [16:0] decoded_count,
	input  logic [2:0]  stop_reason,
	output int          errors,
	output int          pending,
	output int          store_high,
	output int          results_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0]  pixel;
		logic [16:0] count;
		stop_t       stop;
	} status_t;

	status_t expected_q[$];

	logic [3:0]  size_reg;
	logic [16:0] limit_reg;

	int unsigned bit_buf;
	int unsigned bit_cnt;
	int unsigned width;
	int unsigned next_code;
	int unsigned prev_code;
	bit          want_literal;
	int unsigned out_pos;
	stop_t       halt;
	int unsigned frame_size;

	bit [11:0] dict_prefix[DICT_SIZE];
	bit [7:0]  dict_suffix[DICT_SIZE];
	bit [7:0]  pixels[MAX_PIXELS];
	bit [7:0]  chain[DICT_SIZE];

	function automatic int unsigned limit_now();
		return (limit_reg > MAX_PIXELS) ? MAX_PIXELS : limit_reg;
	endfunction

	function automatic int unsigned clear_code();
		return 1 << frame_size;
	endfunction

	function automatic void restart_dict();
		width = frame_size + 1;
		next_code = clear_code() + 2;
		prev_code = 0;
		want_literal = 1;
	endfunction

	function automatic void put_pixel(logic [7:0] v);
		if (out_pos < limit_now()) begin
			pixels[out_pos] = v;
			out_pos++;
		end
	endfunction

	function automatic logic [7:0] head_of(int unsigned c);
		int unsigned g;
		g = 0;
		c &= DICT_SIZE - 1;
		while (c >= clear_code() && g < DICT_SIZE) begin
			c = dict_prefix[c];
			g++;
		end
		return c[7:0];
	endfunction

	function automatic void write_string(int unsigned c);
		int unsigned n;
		n = 0;
		c &= DICT_SIZE - 1;
		while (n < DICT_SIZE) begin
			if (c < clear_code()) begin
				chain[n] = c[7:0];
				n++;
				break;
			end
			chain[n] = dict_suffix[c];
			n++;
			c = dict_prefix[c];
		end
		while (n > 0 && out_pos < limit_now()) begin
			n--;
			put_pixel(chain[n]);
		end
	endfunction

	function automatic void decode_code(int unsigned code);
		int unsigned clr;
		int unsigned src;
		clr = clear_code();
		if (code == clr + 1) begin
			halt = STOP_END;
			return;
		end
		if (code == clr) begin
			restart_dict();
			return;
		end
		if (want_literal) begin
			if (code > clr) begin
				halt = STOP_INVALID;
				return;
			end
			put_pixel(code[7:0]);
			prev_code = code;
			want_literal = 0;
			return;
		end
		if (code > next_code) begin
			halt = STOP_INVALID;
			return;
		end
		if (code == next_code) begin
			write_string(prev_code);
			if (out_pos >= limit_now()) begin
				halt = STOP_FULL;
				return;
			end
			put_pixel(head_of(prev_code));
			src = prev_code;
		end else begin
			write_string(code);
			src = code;
		end
		if (next_code < DICT_SIZE) begin
			dict_prefix[next_code] = prev_code[11:0];
			dict_suffix[next_code] = head_of(src);
			next_code++;
			if (next_code >= (1 << width) && width < MAX_WIDTH)
				width++;
		end
		prev_code = code & (DICT_SIZE - 1);
	endfunction

	function automatic void begin_frame();
		bit bad;
		bad = (size_reg < MCS_MIN || size_reg > MCS_MAX);
		frame_size = bad ? MCS_RESET : size_reg;
		bit_buf = 0;
		bit_cnt = 0;
		out_pos = 0;
		halt = STOP_RUNNING;
		restart_dict();
		if (bad)
			halt = STOP_INVALID;
		else if (limit_now() == 0)
			halt = STOP_FULL;
	endfunction

	function automatic void take_byte(logic [7:0] b, logic fin);
		int unsigned code;
		if (halt != STOP_RUNNING)
			return;
		if (out_pos >= limit_now()) begin
			halt = STOP_FULL;
			return;
		end
		bit_buf = (bit_buf | (int'(b) << bit_cnt)) & 32'hFFFFF;
		bit_cnt += 8;
		while (halt == STOP_RUNNING && bit_cnt >= width) begin
			code = bit_buf & ((1 << width) - 1);
			bit_buf >>= width;
			bit_cnt -= width;
			decode_code(code);
			if (halt == STOP_RUNNING && out_pos >= limit_now())
				halt = STOP_FULL;
		end
		if (halt == STOP_RUNNING && fin)
			halt = STOP_DATA;
	endfunction

	function automatic status_t step(logic [1:0] cmd, logic [7:0] b, logic fin,
			logic [15:0] addr);
		status_t r;
		r.pixel = '0;
		case (cmd)
			CMD_START: begin
				begin_frame();
			end
			CMD_DATA: begin
				take_byte(b, fin);
			end
			CMD_READ: begin
				r.pixel = pixels[addr];
			end
			default: ;
		endcase
		r.count = out_pos[16:0];
		r.stop = halt;
		return r;
	endfunction

	initial begin
		errors = 0;
		pending = 0;
		store_high = 0;
		results_seen = 0;
		size_reg = MCS_RESET;
		limit_reg = 17'(MAX_PIXELS);
		frame_size = MCS_RESET;
		bit_buf = 0;
		bit_cnt = 0;
		out_pos = 0;
		halt = STOP_RUNNING;
		restart_dict();
	end

	always @(posedge clk) begin
		status_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result transfer: pixel %0d count %0d stop %0d",
							pixel_value, decoded_count, stop_reason);
				end else begin
					want = expected_q.pop_front();
					if (want.pixel !== pixel_value || want.count !== decoded_count ||
							want.stop !== stop_reason) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: expected pixel %0d count %0d stop %0d, got %0d %0d %0d",
								want.pixel, want.count, want.stop,
								pixel_value, decoded_count, stop_reason);
					end
				end
			end
			if (in_valid && in_ready) begin
				expected_q.push_back(step(command, data_byte, last_byte, read_address));
				if (out_pos > store_high)
					store_high = out_pos;
			end
			if (cfg_write) begin
				if (cfg_index == REG_MIN_CODE_SIZE)
					size_reg = cfg_data[3:0];
				else
					limit_reg = cfg_data;
			end
			pending = expected_q.size();
		end
	end

endmodule

### test/gif_lzw_decoder_test.sv
// ----------------------------------------------------------------------------
// gif_lzw_decoder_test
// Drives frames of LZW codes packed LSB-first through the decoder, with bad
// sizes, limits, invalid and end codes, pixel reads and random stalls on both
// channels. A checker module beside the block predicts and compares.
// ----------------------------------------------------------------------------
module gif_lzw_decoder_test;
	import gld_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk;
	logic        arst_n;
	logic        cfg_write;
	logic        cfg_index;
	logic [16:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  command;
	logic [7:0]  data_byte;
	logic        last_byte;
	logic [15:0] read_address;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  pixel_value;
	logic [16:0] decoded_count;
	logic [2:0]  stop_reason;

	int errors;
	int pending;
	int store_high;
	int results_seen;

	logic took;
	bit   quiet;
	int   items_sent;
	int   frames_sent;
	longint cycles;

	int unsigned enc_size;
	int unsigned enc_width;
	int unsigned enc_next;
	bit          enc_literal;
	longint unsigned enc_bits;
	int unsigned enc_nbits;
	logic [7:0]  frame_bytes[$];

	gif_lzw_decoder dut (.*);

	gif_lzw_decoder_check checker_i (.*);

	initial clk = 0;
	always #10 clk = ~clk;

	always @(posedge clk) took <= in_valid && in_ready;

	always @(negedge clk)
		out_ready <= quiet ? 1'b1 : ($urandom_range(99, 0) >= 17);

	always @(posedge clk) begin
		cycles++;
		if (cycles > 3000000) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic send(logic [1:0] cmd, logic [7:0] b, logic fin, logic [15:0] addr);
		if (!quiet && $urandom_range(99, 0) < 17) begin
			in_valid <= 0;
			repeat ($urandom_range(4, 1)) @(negedge clk);
		end
		in_valid <= 1;
		command <= cmd;
		data_byte <= b;
		last_byte <= fin;
		read_address <= addr;
		@(negedge clk);
		while (!took) @(negedge clk);
		items_sent++;
	endtask

	task automatic read_some(int n);
		repeat (n)
			if (store_high > 0)
				send(CMD_READ, 8'($urandom), 1'($urandom),
					16'($urandom_range(store_high - 1, 0)));
	endtask

	task automatic write_reg(logic idx, logic [16:0] val);
		in_valid <= 0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		cfg_write <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_write <= 0;
		cfg_data <= 17'($urandom);
	endtask

	task automatic open_frame(int unsigned sz);
		enc_size = (sz < MCS_MIN || sz > MCS_MAX) ? MCS_RESET : sz;
		enc_width = enc_size + 1;
		enc_next = (1 << enc_size) + 2;
		enc_literal = 1;
		enc_bits = 0;
		enc_nbits = 0;
		frame_bytes.delete();
	endtask

	task automatic put_code(int unsigned code);
		int unsigned clr;
		clr = 1 << enc_size;
		enc_bits |= longint'(code) << enc_nbits;
		enc_nbits += enc_width;
		while (enc_nbits >= 8) begin
			frame_bytes.push_back(enc_bits[7:0]);
			enc_bits >>= 8;
			enc_nbits -= 8;
		end
		if (code == clr) begin
			enc_width = enc_size + 1;
			enc_next = clr + 2;
			enc_literal = 1;
		end else if (code == clr + 1) begin
		end else if (enc_literal) begin
			enc_literal = 0;
		end else if (enc_next < DICT_SIZE) begin
			enc_next++;
			if (enc_next >= (1 << enc_width) && enc_width < MAX_WIDTH)
				enc_width++;
		end
	endtask

	task automatic ship_frame(bit mark_last, int read_pct);
		if (enc_nbits > 0)
			frame_bytes.push_back(8'($urandom) << enc_nbits | enc_bits[7:0]);
		foreach (frame_bytes[i]) begin
			if ($urandom_range(99, 0) < read_pct)
				read_some(1);
			send(CMD_DATA, frame_bytes[i], mark_last && i == frame_bytes.size() - 1,
				16'($urandom));
		end
		frames_sent++;
	endtask

	task automatic random_frame();
		int unsigned sz;
		int unsigned clr;
		int unsigned n;
		int unsigned c;
		int unsigned r;
		sz = ($urandom_range(99, 0) < 4) ? $urandom_range(15, 9) : $urandom_range(8, 2);
		write_reg(REG_MIN_CODE_SIZE, 17'(sz));
		r = $urandom_range(99, 0);
		write_reg(REG_PIXEL_LIMIT, 17'(r < 3 ? 0 : r < 70 ? $urandom_range(300, 1) :
			r < 85 ? MAX_PIXELS : $urandom_range(131071, 1)));
		send(CMD_START, 8'($urandom), 1'($urandom), 16'($urandom));
		open_frame(sz);
		clr = 1 << enc_size;
		if ($urandom_range(1, 0))
			put_code(clr);
		n = $urandom_range(40, 1);
		repeat (n) begin
			r = $urandom_range(99, 0);
			if (enc_literal)
				c = (r < 3) ? $urandom_range((1 << enc_width) - 1, clr + 2) :
					$urandom_range(clr - 1, 0);
			else if (r < 2)
				c = clr;
			else if (r < 3 && enc_next + 1 < (1 << enc_width))
				c = $urandom_range((1 << enc_width) - 1, enc_next + 1);
			else if (r < 15)
				c = enc_next;
			else begin
				c = $urandom_range(enc_next, 0);
				if (c == clr + 1)
					c = 0;
			end
			put_code(c);
		end
		if ($urandom_range(99, 0) < 70)
			put_code(clr + 1);
		ship_frame($urandom_range(99, 0) < 85, 6);
		if ($urandom_range(99, 0) < 20)
			repeat ($urandom_range(3, 1))
				send(CMD_DATA, 8'($urandom), 1'($urandom), 16'($urandom));
		read_some($urandom_range(4, 0));
		if ($urandom_range(99, 0) < 10)
			send(CMD_NOP, 8'($urandom), 1'($urandom), 16'($urandom));
	endtask

	initial begin
		cycles = 0;
		items_sent = 0;
		frames_sent = 0;
		quiet = 0;
		arst_n = 0;
		cfg_write = 0;
		cfg_index = 0;
		cfg_data = 0;
		in_valid = 0;
		command = CMD_NOP;
		data_byte = 0;
		last_byte = 0;
		read_address = 0;
		out_ready = 0;
		repeat (4) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: reset-size decoding, no-op, bad sizes, zero and oversize limits
		send(CMD_NOP, 8'hFF, 1, 16'hFFFF);
		open_frame(8);
		put_code(256);
		put_code(8'hA5);
		put_code(258);
		put_code(257);
		ship_frame(0, 0);
		send(CMD_READ, 0, 1, 0);
		send(CMD_READ, 0, 0, 2);
		write_reg(REG_MIN_CODE_SIZE, 0);
		send(CMD_START, 0, 1, 0);
		send(CMD_DATA, 8'hFF, 0, 0);
		write_reg(REG_MIN_CODE_SIZE, 15);
		send(CMD_START, 0, 0, 0);
		write_reg(REG_MIN_CODE_SIZE, 9);
		send(CMD_START, 0, 0, 0);
		write_reg(REG_MIN_CODE_SIZE, 2);
		write_reg(REG_PIXEL_LIMIT, 0);
		send(CMD_START, 0, 0, 0);
		send(CMD_DATA, 8'h00, 1, 0);
		write_reg(REG_PIXEL_LIMIT, 131071);
		// first code above the end code, then two clear codes in a row
		send(CMD_START, 0, 0, 0);
		send(CMD_DATA, 8'b00_000_110, 0, 0);
		send(CMD_START, 0, 0, 0);
		send(CMD_DATA, 8'b111_001_00, 0, 0);
		// last byte with leftover bits
		send(CMD_START, 0, 0, 0);
		send(CMD_DATA, 8'b11_010_001, 1, 0);
		send(CMD_DATA, 8'h00, 0, 0);
		// limit lowered mid-frame
		send(CMD_START, 0, 0, 0);
		send(CMD_DATA, 8'b00_011_010, 0, 0);
		write_reg(REG_PIXEL_LIMIT, 1);
		send(CMD_DATA, 8'h00, 0, 0);
		// limit hit on a code equal to the next free code
		write_reg(REG_PIXEL_LIMIT, 2);
		send(CMD_START, 0, 0, 0);
		send(CMD_DATA, 8'b00_110_001, 0, 0);

		// one full-size frame of runs fills the whole pixel store
		quiet = 1;
		write_reg(REG_PIXEL_LIMIT, 17'(MAX_PIXELS));
		send(CMD_START, 0, 0, 0);
		open_frame(2);
		put_code(4);
		put_code(3);
		repeat (400) put_code(enc_next);
		put_code(5);
		ship_frame(1, 0);
		read_some(40);
		quiet = 0;

		while (items_sent < 1700)
			random_frame();
		read_some(30);

		in_valid <= 0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (50) @(negedge clk);
		$display("covered %0d transfers in %0d frames, %0d results checked",
			items_sent, frames_sent, results_seen);
		$display("pixel store filled to %0d entries", store_high);
		if (errors == 0 && pending == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
